@@ rtl/ket_pkg.sv @@
// Package for the keyed endpoint table: action and status codes, the entry record and
// the sequencer state type. No dependencies.
package ket_pkg;

  typedef enum logic [1:0] {
    ACT_ANNOUNCE = 2'd0,
    ACT_UPDATE   = 2'd1,
    ACT_SWEEP    = 2'd2,
    ACT_READ     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_UPDATED   = 3'd4,
    ST_SWEPT     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_WR,
    S_DONE
  } seq_state_e;

  localparam int unsigned EntryW = 32 + 16 + 16 + 32 + 32 + 32 + 32 + 8 + 32 + 32;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] sport;
    logic [15:0] mport;
    logic [31:0] seen;
    logic [31:0] mid;
    logic [31:0] rtt;
    logic [31:0] usage;
    logic [7:0]  cores;
    logic [31:0] bw;
    logic [31:0] freq;
  } entry_t;

  localparam logic [19:0] ExpiryReset = 20'd3000;

endpackage

@@ rtl/keyed_endpoint_table_with_aging.sv @@
// Keyed endpoint table with aging: the sequencer, the shared key/age compare and the
// result registers around one entry RAM. Depends on ket_pkg, ket_ram.
// Each announce, update or sweep walks the table one stored entry at a time, through S_RD
// and S_CHK, using a single RAM read port and a shared key/age compare unit; a read fetches
// only the entry that it names. Once the result is taken the block is ready again in the
// next cycle; it takes no new request while one is still in flight. The single read port
// and the serial compare set the pace of the walk. A sweep compacts survivors in place,
// writing each kept entry to the next free slot.
module keyed_endpoint_table_with_aging import ket_pkg::*; #(
  parameter int unsigned Capacity = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] ip_address_i,
  input  logic [15:0] svc_port_i,
  input  logic [15:0] mon_port_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  entry_index_i,
  input  logic [31:0] monitor_id_i,
  input  logic signed [31:0] rtt_i,
  input  logic [31:0] proc_load_i,
  input  logic [7:0]  core_count_i,
  input  logic [31:0] bandwidth_i,
  input  logic [31:0] frequency_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [8:0]  entry_count_o,
  output logic [8:0]  removed_count_o,
  output logic [31:0] out_ip_address_o,
  output logic [15:0] out_svc_port_o,
  output logic [15:0] out_mon_port_o,
  output logic [31:0] out_monitor_id_o,
  output logic signed [31:0] out_rtt_o,
  output logic [31:0] out_proc_load_o,
  output logic [7:0]  out_core_count_o,
  output logic [31:0] out_bandwidth_o,
  output logic [31:0] out_frequency_o
);

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);

  seq_state_e state_q, state_d;
  logic [19:0]   expiry_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] keep_q, keep_d;
  logic [8:0]    removed_q, removed_d;
  logic [2:0]    status_q, status_d;
  logic          out_valid_q, out_valid_d;
  logic          rdok_q, rdok_d;
  action_e       act_q;
  logic [31:0]   addr_q, now_q, mid_q, rtt_q, usage_q, bw_q, freq_q;
  logic [15:0]   sport_q, mport_q;
  logic [7:0]    cores_q, eidx_q;
  entry_t        rdata, wdata, rd_q, rd_d;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic          hit, aged;

  ket_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign hit  = (rdata.addr == addr_q) && (rdata.sport == sport_q);
  assign aged = ((now_q - rdata.seen) >= {12'd0, expiry_q});
  assign raddr = idx_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      expiry_q    <= ExpiryReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        expiry_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    keep_q    <= keep_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    rdok_q    <= rdok_d;
    rd_q      <= rd_d;
    if (in_valid_i && in_ready_o) begin
      act_q   <= action_e'(action_i);
      addr_q  <= ip_address_i;
      sport_q <= svc_port_i;
      mport_q <= mon_port_i;
      now_q   <= now_ms_i;
      eidx_q  <= entry_index_i;
      mid_q   <= monitor_id_i;
      rtt_q   <= rtt_i;
      usage_q <= proc_load_i;
      cores_q <= core_count_i;
      bw_q    <= bandwidth_i;
      freq_q  <= frequency_i;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    keep_d      = keep_q;
    removed_d   = removed_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    rdok_d      = rdok_q;
    rd_d        = rd_q;
    we          = 1'b0;
    waddr       = idx_q[AW-1:0];
    wdata       = rdata;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          removed_d = '0;
          keep_d    = '0;
          rdok_d    = 1'b0;
          if (action_e'(action_i) == ACT_READ) begin
            idx_d = (entry_index_i < {{(9-CW){1'b0}}, count_q}) ?
                    CW'(entry_index_i) : '0;
          end else begin
            idx_d = '0;
          end
          state_d = S_RD;
        end
      end
      S_RD: begin
        // The RAM read for idx_q is issued here; data arrives next cycle.
        if (act_q == ACT_READ) begin
          state_d = S_CHK;
        end else if (idx_q >= count_q) begin
          case (act_q)
            ACT_ANNOUNCE: begin
              if (count_q >= CW'(Capacity)) begin
                status_d = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = count_q[AW-1:0];
                wdata    = '0;
                wdata.addr  = addr_q;
                wdata.sport = sport_q;
                wdata.mport = mport_q;
                wdata.seen  = now_q;
                count_d  = count_q + 1'b1;
                status_d = ST_INSERTED;
              end
            end
            ACT_UPDATE: status_d = ST_NOT_FOUND;
            default: begin
              count_d  = keep_q;
              status_d = ST_SWEPT;
            end
          endcase
          state_d = S_DONE;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        case (act_q)
          ACT_READ: begin
            rdok_d   = ({1'b0, eidx_q} < {{(9-CW){1'b0}}, count_q});
            rd_d     = rdata;
            status_d = rdok_d ? ST_REFRESHED : ST_NOT_FOUND;
            state_d  = S_DONE;
          end
          ACT_SWEEP: begin
            if (aged) begin
              removed_d = removed_q + 1'b1;
            end else begin
              we     = (keep_q != idx_q);
              waddr  = keep_q[AW-1:0];
              keep_d = keep_q + 1'b1;
            end
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
          default: begin
            if (hit) begin
              we    = 1'b1;
              wdata.seen = now_q;
              if (act_q == ACT_UPDATE) begin
                wdata.mid   = mid_q;
                wdata.rtt   = rtt_q;
                wdata.usage = usage_q;
                wdata.cores = cores_q;
                wdata.bw    = bw_q;
                wdata.freq  = freq_q;
                status_d    = ST_UPDATED;
              end else begin
                status_d = ST_REFRESHED;
              end
              state_d = S_DONE;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_RD;
            end
          end
        endcase
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        state_d     = S_WR;
      end
      S_WR: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign entry_count_o      = 9'(count_q);
  assign removed_count_o    = removed_q;
  assign out_ip_address_o   = rdok_q ? rd_q.addr  : '0;
  assign out_svc_port_o     = rdok_q ? rd_q.sport : '0;
  assign out_mon_port_o     = rdok_q ? rd_q.mport : '0;
  assign out_monitor_id_o   = rdok_q ? rd_q.mid   : '0;
  assign out_rtt_o          = rdok_q ? rd_q.rtt   : '0;
  assign out_proc_load_o    = rdok_q ? rd_q.usage : '0;
  assign out_core_count_o   = rdok_q ? rd_q.cores : '0;
  assign out_bandwidth_o    = rdok_q ? rd_q.bw    : '0;
  assign out_frequency_o    = rdok_q ? rd_q.freq  : '0;

endmodule

@@ rtl/ket_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ket_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ test/ket_checker.sv @@
// Checker for the keyed endpoint table: watches the request and result channels, keeps its
// own copy of the table and the expiry setting, and compares every result. Depends on ket_pkg.
`timescale 1ns / 100ps
module ket_checker import ket_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] ip_address_i,
  input  logic [15:0] svc_port_i,
  input  logic [15:0] mon_port_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  entry_index_i,
  input  logic [31:0] monitor_id_i,
  input  logic [31:0] rtt_i,
  input  logic [31:0] proc_load_i,
  input  logic [7:0]  core_count_i,
  input  logic [31:0] bandwidth_i,
  input  logic [31:0] frequency_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [8:0]  entry_count_i,
  input  logic [8:0]  removed_count_i,
  input  logic [31:0] out_ip_address_i,
  input  logic [15:0] out_svc_port_i,
  input  logic [15:0] out_mon_port_i,
  input  logic [31:0] out_monitor_id_i,
  input  logic [31:0] out_rtt_i,
  input  logic [31:0] out_proc_load_i,
  input  logic [7:0]  out_core_count_i,
  input  logic [31:0] out_bandwidth_i,
  input  logic [31:0] out_frequency_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          swept_o
);
  localparam int Slots = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  count;
    logic [8:0]  removed;
    entry_t      ent;
  } reply_t;

  entry_t      table_q [Slots];
  int          fill;
  logic [19:0] expiry;
  reply_t      replies_q [$];

  function automatic int find_key(logic [31:0] a, logic [15:0] p);
    for (int i = 0; i < fill; i++)
      if (table_q[i].addr == a && table_q[i].sport == p) return i;
    return -1;
  endfunction

  task automatic predict_request();
    reply_t r;
    entry_t e;
    int pos;
    int keep;
    r = '0;
    pos = find_key(ip_address_i, svc_port_i);
    case (action_e'(action_i))
      ACT_ANNOUNCE: begin
        if (pos >= 0) begin
          table_q[pos].seen = now_ms_i;
          r.status = ST_REFRESHED;
        end else if (fill >= Slots) begin
          r.status = ST_FULL;
        end else begin
          e = '0;
          e.addr = ip_address_i;
          e.sport = svc_port_i;
          e.mport = mon_port_i;
          e.seen = now_ms_i;
          table_q[fill] = e;
          fill++;
          r.status = ST_INSERTED;
        end
      end
      ACT_UPDATE: begin
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          table_q[pos].mid = monitor_id_i;
          table_q[pos].rtt = rtt_i;
          table_q[pos].usage = proc_load_i;
          table_q[pos].cores = core_count_i;
          table_q[pos].bw = bandwidth_i;
          table_q[pos].freq = frequency_i;
          table_q[pos].seen = now_ms_i;
          r.status = ST_UPDATED;
        end
      end
      ACT_SWEEP: begin
        keep = 0;
        for (int i = 0; i < fill; i++) begin
          if (now_ms_i - table_q[i].seen >= {12'd0, expiry}) begin
            r.removed++;
          end else begin
            table_q[keep] = table_q[i];
            keep++;
          end
        end
        fill = keep;
        swept_o += r.removed;
        r.status = ST_SWEPT;
      end
      default: begin
        if (entry_index_i < fill) begin
          r.status = ST_REFRESHED;
          r.ent = table_q[entry_index_i];
          r.ent.seen = '0;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
    endcase
    r.count = 9'(fill);
    replies_q.push_back(r);
  endtask

  task automatic field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors_o++;
    end
  endtask

  task automatic check_result();
    reply_t r;
    if (replies_q.size() == 0) begin
      $display("%0t: result with no request waiting, status %0d", $time, status_i);
      errors_o++;
      return;
    end
    r = replies_q.pop_front();
    results_o++;
    field("status", 32'(r.status), 32'(status_i));
    field("entry_count", 32'(r.count), 32'(entry_count_i));
    field("removed_count", 32'(r.removed), 32'(removed_count_i));
    field("ip_address", r.ent.addr, out_ip_address_i);
    field("svc_port", 32'(r.ent.sport), 32'(out_svc_port_i));
    field("mon_port", 32'(r.ent.mport), 32'(out_mon_port_i));
    field("monitor_id", r.ent.mid, out_monitor_id_i);
    field("rtt", r.ent.rtt, out_rtt_i);
    field("proc_load", r.ent.usage, out_proc_load_i);
    field("core_count", 32'(r.ent.cores), 32'(out_core_count_i));
    field("bandwidth", r.ent.bw, out_bandwidth_i);
    field("frequency", r.ent.freq, out_frequency_i);
  endtask

  initial begin
    fill = 0;
    expiry = ExpiryReset;
    errors_o = 0;
    results_o = 0;
    swept_o = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_we_i) expiry = cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict_request();
    end
    pending_o = replies_q.size();
  end
endmodule

@@ test/keyed_endpoint_table_with_aging_tb.sv @@
// Testbench top for the keyed endpoint table: drives directed and random requests with
// bursty sending and a stalling receiver, and gives the verdict. Depends on ket_pkg, ket_checker.
`timescale 1ns / 100ps
module keyed_endpoint_table_with_aging_tb;
  import ket_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [19:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [31:0] ip_address_i = '0;
  logic [15:0] svc_port_i = '0;
  logic [15:0] mon_port_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [7:0]  entry_index_i = '0;
  logic [31:0] monitor_id_i = '0;
  logic signed [31:0] rtt_i = '0;
  logic [31:0] proc_load_i = '0;
  logic [7:0]  core_count_i = '0;
  logic [31:0] bandwidth_i = '0;
  logic [31:0] frequency_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [8:0]  entry_count_o;
  logic [8:0]  removed_count_o;
  logic [31:0] out_ip_address_o;
  logic [15:0] out_svc_port_o;
  logic [15:0] out_mon_port_o;
  logic [31:0] out_monitor_id_o;
  logic signed [31:0] out_rtt_o;
  logic [31:0] out_proc_load_o;
  logic [7:0]  out_core_count_o;
  logic [31:0] out_bandwidth_o;
  logic [31:0] out_frequency_o;

  int          errors;
  int          pending;
  int          results;
  int          swept;
  int          sent;
  bit          hold_off;
  logic [31:0] clock_ms;
  logic [31:0] key_addr [8];
  logic [15:0] key_port [8];

  keyed_endpoint_table_with_aging u_dut (.*);

  ket_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .action_i, .ip_address_i, .svc_port_i,
    .mon_port_i, .now_ms_i, .entry_index_i, .monitor_id_i, .rtt_i,
    .proc_load_i, .core_count_i, .bandwidth_i, .frequency_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .entry_count_i(entry_count_o), .removed_count_i(removed_count_o),
    .out_ip_address_i(out_ip_address_o), .out_svc_port_i(out_svc_port_o),
    .out_mon_port_i(out_mon_port_o), .out_monitor_id_i(out_monitor_id_o),
    .out_rtt_i(out_rtt_o), .out_proc_load_i(out_proc_load_o),
    .out_core_count_i(out_core_count_o), .out_bandwidth_i(out_bandwidth_o),
    .out_frequency_i(out_frequency_o), .errors_o(errors), .pending_o(pending),
    .results_o(results), .swept_o(swept)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("keyed_endpoint_table_with_aging_tb: FAIL");
    $finish;
  end

  // The receiver stalls on its own pattern, with one long hold-off on request.
  initial begin
    int mode;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      mode = (sent / 200) % 3;
      if (mode == 0) out_ready_i <= 1'b1;
      else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
      else out_ready_i <= ($urandom_range(0, 2) == 0);
    end
  end

  task automatic send(action_e act, logic [31:0] a, logic [15:0] p, logic [31:0] t,
                      logic [7:0] idx);
    action_i       <= act;
    ip_address_i   <= a;
    svc_port_i     <= p;
    mon_port_i     <= 16'($urandom());
    now_ms_i       <= t;
    entry_index_i  <= idx;
    monitor_id_i   <= $urandom();
    rtt_i          <= $urandom();
    proc_load_i    <= $urandom();
    core_count_i   <= 8'($urandom());
    bandwidth_i    <= $urandom();
    frequency_i    <= $urandom();
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
    if ($urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_expiry(logic [19:0] v);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_request();
    int k;
    int pick;
    k = $urandom_range(0, 7);
    clock_ms = clock_ms + $urandom_range(0, 700);
    pick = $urandom_range(0, 99);
    if (pick < 40) send(ACT_ANNOUNCE, key_addr[k], key_port[k], clock_ms, 0);
    else if (pick < 60) send(ACT_UPDATE, key_addr[k], key_port[k], clock_ms, 0);
    else if (pick < 68) send(ACT_UPDATE, $urandom(), 16'($urandom()), clock_ms, 0);
    else if (pick < 78) send(ACT_SWEEP, $urandom(), 16'($urandom()), clock_ms,
                             8'($urandom()));
    else if (pick < 95) send(ACT_READ, $urandom(), 16'($urandom()), clock_ms,
                             8'($urandom_range(0, 17)));
    else send(ACT_READ, $urandom(), 16'($urandom()), $urandom(), 8'($urandom()));
  endtask

  initial begin
    logic [19:0] settings [5];
    sent = 0;
    hold_off = 1'b0;
    clock_ms = 32'hFFFF_F000;
    settings = '{20'd1, 20'd1_000_000, 20'd2500, 20'd400, 20'hFFFFF};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty read and update, fill past full, refresh, read ends, sweep over wrap.
    send(ACT_READ, 0, 0, 0, 0);
    send(ACT_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 0, 0);
    for (int i = 0; i < 17; i++)
      send(ACT_ANNOUNCE, (i == 0) ? 32'hFFFF_FFFF : 32'h0A00_0000 + i,
           (i == 0) ? 16'hFFFF : 16'(i), 32'hFFFF_FF00, 0);
    send(ACT_ANNOUNCE, 32'h0A00_0003, 16'd3, 32'd50, 0);
    send(ACT_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 32'd100, 0);
    send(ACT_READ, 0, 0, 0, 8'd0);
    send(ACT_READ, 0, 0, 0, 8'd15);
    send(ACT_READ, 0, 0, 0, 8'd255);
    send(ACT_SWEEP, 0, 0, 32'd2000, 0);
    send(ACT_READ, 0, 0, 0, 8'd1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      set_expiry(settings[ph]);
      for (int k = 0; k < 8; k++) begin
        key_addr[k] = (k < 2) ? {k[0] ? 32'hFFFF_FFFF : 32'h0} : $urandom();
        key_port[k] = (k == 1) ? 16'hFFFF : 16'($urandom());
      end
      if (ph == 2) hold_off = 1'b1;
      for (int n = 0; n < 345; n++) random_request();
      drain();
    end

    $display("Covered %0d requests over five expiry settings with %0d results checked;",
             sent, results);
    $display("sweeps removed %0d entries in total.", swept);
    if (errors == 0) begin
      $display("keyed_endpoint_table_with_aging_tb: PASS");
    end else begin
      $display("keyed_endpoint_table_with_aging_tb: FAIL");
    end
    $finish;
  end
endmodule
